[src/multi_stream_timestamp_aligner_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef MULTI_STREAM_TIMESTAMP_ALIGNER_TOP_DEFINES_SVH
`define MULTI_STREAM_TIMESTAMP_ALIGNER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MSTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define MSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/msta_pkg.sv]
// ---------------------------------------------------------------------------
// msta_pkg
// Types and constants shared by the timestamp aligner modules.
// ---------------------------------------------------------------------------
package msta_pkg;

  localparam logic        CMD_PUSH    = 1'b0;
  localparam logic        CMD_POP     = 1'b1;
  localparam logic [63:0] DEFAULT_TOL = 64'd16666667;
  localparam logic        REG_STREAMS = 1'b0;
  localparam logic        REG_TOL     = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  cam;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic [63:0] tag;
  } cmd_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  cam;
    logic [31:0] seq;
    logic [63:0] stamp;
    logic [63:0] tag;
    logic        last;
  } res_t;

endpackage

[src/msta_ram.sv]
// ---------------------------------------------------------------------------
// msta_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module msta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/msta_front.sv]
// ---------------------------------------------------------------------------
// msta_front
// Accept command beats and place them in a short queue for the engine.
// ---------------------------------------------------------------------------
module msta_front #(
  parameter int QDEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  msta_pkg::cmd_t  cmd_in,
  output logic            q_valid,
  output msta_pkg::cmd_t  q_head,
  input  logic            q_pop
);

  localparam int PW = $clog2(QDEPTH);

  msta_pkg::cmd_t   buf_r [QDEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             push;

  assign busy    = (cnt_r == (PW+1)'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_head  = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      buf_r[wp_r] <= cmd_in;
    end
  end

endmodule

[src/msta_engine.sv]
// ---------------------------------------------------------------------------
// msta_engine
// Carry out queued push and pop commands against the per-stream stores.
// ---------------------------------------------------------------------------
module msta_engine #(
  parameter int NS = 4,
  parameter int QD = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  msta_pkg::cmd_t  q_head,
  output logic            q_pop,
  input  logic [2:0]      streams,
  input  logic [63:0]     tol,
  output logic            res_valid,
  output msta_pkg::res_t  res
);

  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int QW = $clog2(QD);
  localparam int AW = SW + QW;
  localparam int CW = $clog2(QD + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PUSH  = 9'b000000010,
    ST_SHIFT = 9'b000000100,
    ST_HEAD  = 9'b000001000,
    ST_SCAN  = 9'b000010000,
    ST_CHECK = 9'b000100000,
    ST_EMIT  = 9'b001000000,
    ST_REM   = 9'b010000000,
    ST_WAIT  = 9'b100000000
  } state_t;

  state_t          st_r, st_nxt;
  logic [CW-1:0]   fill_r [NS];
  logic [SW-1:0]   s_r, s_nxt;
  logic [QW-1:0]   i_r, i_nxt;
  logic [QW-1:0]   best_r, best_nxt;
  logic [QW-1:0]   pick_r [NS];
  logic [63:0]     anchor_r, anchor_nxt;
  logic [63:0]     bd_r, bd_nxt;
  logic [3:0]      nact;
  logic [SW:0]     sidx;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wseq, rseq;
  logic [63:0]     wstamp, rstamp, wtag, rtag;
  logic [63:0]     delta;

  assign nact  = (4'(streams) < 4'(NS)) ? 4'(streams) : 4'(NS);
  assign delta = (rstamp > anchor_r) ? rstamp - anchor_r : anchor_r - rstamp;

  msta_ram #(.WIDTH(32), .DEPTH(NS*QD)) u_seq (
    .clk, .we, .waddr, .wdata(wseq), .raddr, .rdata(rseq));
  msta_ram #(.WIDTH(64), .DEPTH(NS*QD)) u_stamp (
    .clk, .we, .waddr, .wdata(wstamp), .raddr, .rdata(rstamp));
  msta_ram #(.WIDTH(64), .DEPTH(NS*QD)) u_tag (
    .clk, .we, .waddr, .wdata(wtag), .raddr, .rdata(rtag));

  always_comb begin
    st_nxt      = st_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    best_nxt    = best_r;
    anchor_nxt  = anchor_r;
    bd_nxt      = bd_r;
    q_pop       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    we          = 1'b0;
    waddr       = {s_r, i_r};
    raddr       = {s_r, i_r};
    wseq        = rseq;
    wstamp      = rstamp;
    wtag        = rtag;
    sidx        = {1'b0, s_r} + 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          s_nxt = '0;
          i_nxt = '0;
          if (q_head.cmd == msta_pkg::CMD_PUSH) begin
            if (4'(q_head.cam) >= nact) begin
              q_pop     = 1'b1;
              res_valid = 1'b1;
              res.last  = 1'b1;
            end else begin
              s_nxt = SW'(q_head.cam);
              if (fill_r[SW'(q_head.cam)] == CW'(QD)) begin
                i_nxt       = QW'(1);
                raddr       = {SW'(q_head.cam), QW'(1)};
                st_nxt      = ST_SHIFT;
              end else begin
                st_nxt = ST_PUSH;
              end
            end
          end else begin
            raddr       = '0;
            st_nxt      = ST_HEAD;
          end
        end
      end
      ST_SHIFT: begin
        // drop the oldest record by moving each entry down one slot
        we    = 1'b1;
        waddr = {s_r, i_r - 1'b1};
        if (i_r == QW'(QD-1)) begin
          st_nxt = ST_PUSH;
        end else begin
          i_nxt       = i_r + 1'b1;
          raddr       = {s_r, i_r + 1'b1};
        end
      end
      ST_PUSH: begin
        we        = 1'b1;
        waddr     = {s_r, (fill_r[s_r] == CW'(QD)) ? QW'(QD-1) : QW'(fill_r[s_r])};
        wseq      = q_head.seq;
        wstamp    = q_head.stamp;
        wtag      = q_head.tag;
        q_pop     = 1'b1;
        res_valid = 1'b1;
        res.accepted = 1'b1;
        res.last  = 1'b1;
        st_nxt    = ST_IDLE;
      end
      ST_HEAD: begin
        // anchor is the latest head stamp over active streams
        if (fill_r[s_r] == '0) begin
          q_pop     = 1'b1;
          res_valid = 1'b1;
          res.last  = 1'b1;
          st_nxt    = ST_IDLE;
        end else begin
          if (s_r == '0 || rstamp > anchor_r) begin
            anchor_nxt = rstamp;
          end
          if (sidx == (SW+1)'(nact)) begin
            s_nxt       = '0;
            i_nxt       = '0;
            raddr       = '0;
            st_nxt      = ST_SCAN;
          end else begin
            s_nxt       = s_r + 1'b1;
            raddr       = {s_r + 1'b1, QW'(0)};
          end
        end
      end
      ST_SCAN: begin
        if (i_r == '0 || delta < bd_r) begin
          best_nxt = i_r;
          bd_nxt   = delta;
        end
        if (CW'(i_r) + 1'b1 == fill_r[s_r]) begin
          st_nxt = ST_CHECK;
        end else begin
          i_nxt       = i_r + 1'b1;
          raddr       = {s_r, i_r + 1'b1};
        end
      end
      ST_CHECK: begin
        if (bd_r > tol) begin
          q_pop     = 1'b1;
          res_valid = 1'b1;
          res.last  = 1'b1;
          st_nxt    = ST_IDLE;
        end else if (sidx == (SW+1)'(nact)) begin
          s_nxt       = '0;
          raddr       = {SW'(0), (s_r == '0) ? best_r : pick_r[0]};
          st_nxt      = ST_EMIT;
        end else begin
          s_nxt       = s_r + 1'b1;
          i_nxt       = '0;
          raddr       = {s_r + 1'b1, QW'(0)};
          st_nxt      = ST_SCAN;
        end
      end
      ST_EMIT: begin
        res_valid    = 1'b1;
        res.accepted = 1'b1;
        res.cam      = 2'(s_r);
        res.seq      = rseq;
        res.stamp    = rstamp;
        res.tag      = rtag;
        res.last     = (sidx == (SW+1)'(nact));
        i_nxt        = pick_r[s_r];
        if (CW'(pick_r[s_r]) + 1'b1 < fill_r[s_r]) begin
          raddr       = {s_r, pick_r[s_r] + 1'b1};
          st_nxt      = ST_REM;
        end else begin
          st_nxt = ST_WAIT;
        end
      end
      ST_REM: begin
        // close the gap left by the emitted record
        we    = 1'b1;
        waddr = {s_r, i_r};
        if (CW'(i_r) + 2'd2 < fill_r[s_r]) begin
          i_nxt       = i_r + 1'b1;
          raddr       = {s_r, i_r + 2'd2};
        end else begin
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sidx == (SW+1)'(nact)) begin
          q_pop  = 1'b1;
          st_nxt = ST_IDLE;
        end else begin
          s_nxt       = s_r + 1'b1;
          raddr       = {s_r + 1'b1, pick_r[s_r + 1'b1]};
          st_nxt      = ST_EMIT;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      for (int k = 0; k < NS; k++) begin
        fill_r[k] <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      if (st_r == ST_PUSH && fill_r[s_r] != CW'(QD)) begin
        fill_r[s_r] <= fill_r[s_r] + 1'b1;
      end
      if (st_r == ST_WAIT) begin
        fill_r[s_r] <= fill_r[s_r] - 1'b1;
      end
    end
    s_r      <= s_nxt;
    i_r      <= i_nxt;
    best_r   <= best_nxt;
    anchor_r <= anchor_nxt;
    bd_r     <= bd_nxt;
    if (st_r == ST_CHECK) begin
      pick_r[s_r] <= best_r;
    end
  end

endmodule

[src/multi_stream_timestamp_aligner_top.sv]
// ---------------------------------------------------------------------------
// multi_stream_timestamp_aligner_top
// Per-stream frame-record queues with aligned-set extraction.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive in_* fields and raise start; a beat is taken when start is
//   high and busy is low. A two-entry command queue decouples the front from
//   the engine; it holds up to two commands, counting the one being worked on.
//   Output: each result shows for one cycle with out_valid, in the cycle after
//   the engine makes it; the receiver cannot stall. out_last_frame marks the
//   final result of a command.
//   Push: a decode step, then the write; when the stream's queue is full,
//   the oldest record is first dropped by moving each entry down one slot.
//   Pop: a decode step, one anchor step per active stream, one search step
//   per stored entry plus a check per stream, then per stream an emit step,
//   one step per entry moved and one to retire, paced by the single read
//   port of the record store. A failed pop ends at the stage that finds it.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is stream_count, 1 is the tolerance. Write only while idle.
//   Reset: all queues empty, stream_count = MAX_STREAMS, tolerance default.
// ---------------------------------------------------------------------------
module multi_stream_timestamp_aligner_top #(
  parameter int MAX_STREAMS = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [2:0]  in_cam_index,
  input  logic [31:0] in_seq_number,
  input  logic [63:0] in_stamp_ns,
  input  logic [63:0] in_user_tag,
  output logic        out_valid,
  output logic        out_accepted,
  output logic [1:0]  out_cam,
  output logic [31:0] out_seq,
  output logic [63:0] out_stamp,
  output logic [63:0] out_tag,
  output logic        out_last_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  msta_pkg::cmd_t cmd_in, q_head;
  msta_pkg::res_t res;
  logic           q_valid, q_pop, res_valid;
  logic [2:0]     streams_r;
  logic [63:0]    tol_r;

  assign cmd_in = '{cmd: in_cmd, cam: in_cam_index, seq: in_seq_number,
                    stamp: in_stamp_ns, tag: in_user_tag};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streams_r <= 3'(MAX_STREAMS);
      tol_r     <= msta_pkg::DEFAULT_TOL;
    end else if (cfg_valid) begin
      if (cfg_index == msta_pkg::REG_STREAMS) begin
        streams_r <= (cfg_data[2:0] == '0 || 32'(cfg_data[2:0]) > MAX_STREAMS) ?
                     3'(MAX_STREAMS) : cfg_data[2:0];
      end else begin
        tol_r <= (cfg_data == '0) ? msta_pkg::DEFAULT_TOL : cfg_data;
      end
    end
  end

  msta_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .start, .busy, .cmd_in, .q_valid, .q_head, .q_pop);

  msta_engine #(.NS(MAX_STREAMS), .QD(QUEUE_DEPTH)) u_engine (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .streams(streams_r), .tol(tol_r),
    .res_valid, .res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
    out_accepted   <= res.accepted;
    out_cam        <= res.cam;
    out_seq        <= res.seq;
    out_stamp      <= res.stamp;
    out_tag        <= res.tag;
    out_last_frame <= res.last;
  end

endmodule

[src/msta_checker.sv]
// ---------------------------------------------------------------------------
// msta_checker
// Port-level checks on the timestamp aligner.
// ---------------------------------------------------------------------------
`include "multi_stream_timestamp_aligner_top_defines.svh"

module msta_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_accepted,
  input logic [1:0] out_cam,
  input logic       out_last_frame,
  input logic       cfg_ready
);

  `MSTA_ASSERT_IMP(a_rej_last, clk, rst_n, out_valid && !out_accepted, out_last_frame, "rejected result not last")
  `MSTA_ASSERT_IMP(a_rej_cam, clk, rst_n, out_valid && !out_accepted, out_cam == 2'd0, "rejected result has cam")
  `MSTA_ASSERT_NEXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_valid, "result during reset")
  `MSTA_ASSERT_IMP(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "config not ready")

endmodule

bind multi_stream_timestamp_aligner_top msta_checker u_msta_checker (
  .clk, .rst_n, .out_valid, .out_accepted, .out_cam, .out_last_frame, .cfg_ready);
